@@ sv/mhpq_pkg.sv @@
package mhpq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // wide enough for the right child index of the last slot
    localparam int CH_W     = IDX_W + 2;
    localparam int OCC_W    = 5;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [3:0]         source;
        logic [15:0]        position;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   action;
        entry_t entry;
    } op_req_t;

    typedef struct packed {
        entry_t          entry;
        status_t         status;
        logic [OCC_W-1:0] occupancy;
    } op_rsp_t;

endpackage

@@ sv/mhpq_ram.sv @@
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ sv/mhpq_engine.sv @@
module mhpq_engine (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  mhpq_pkg::op_req_t       req,
    output logic                    idle,
    input  logic                    rsp_ready,
    output logic                    done,
    output mhpq_pkg::op_rsp_t       rsp
);

    typedef enum logic [2:0] {
        S_IDLE, S_UP, S_UP_CMP, S_DN_LOAD, S_DN, S_DN_CMP, S_FIN
    } state_t;

    state_t                           state_reg, state_next;
    logic [mhpq_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [mhpq_pkg::IDX_W-1:0]       hole_reg, hole_next;
    mhpq_pkg::entry_t                 mov_reg, mov_next;
    mhpq_pkg::entry_t                 out_reg, out_next;
    mhpq_pkg::status_t                status_reg, status_next;

    logic                             ram_we;
    logic [mhpq_pkg::IDX_W-1:0]       ram_waddr, ram_ra, ram_rb;
    mhpq_pkg::entry_t                 ram_wdata;
    logic [mhpq_pkg::ENTRY_W-1:0]     rdata_a, rdata_b;
    mhpq_pkg::entry_t                 rd_a, rd_b;

    logic [mhpq_pkg::CH_W-1:0]        left_w, right_w, count_w;
    logic [mhpq_pkg::CNT_W-1:0]       count_dec;
    logic                             left_ok, right_ok, pick_left, pick_right;
    logic signed [31:0]               best_val;

    mhpq_ram #(
        .WIDTH (mhpq_pkg::ENTRY_W),
        .DEPTH (mhpq_pkg::CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_ra),
        .rdata_a (rdata_a),
        .raddr_b (ram_rb),
        .rdata_b (rdata_b)
    );

    assign rd_a      = mhpq_pkg::entry_t'(rdata_a);
    assign rd_b      = mhpq_pkg::entry_t'(rdata_b);
    assign count_w   = mhpq_pkg::CH_W'(count_reg);
    assign count_dec = count_reg - 1'b1;
    assign left_w    = {1'b0, hole_reg, 1'b1};
    assign right_w   = left_w + 1'b1;
    assign left_ok   = left_w < count_w;
    assign right_ok  = right_w < count_w;

    // child choice: left if strictly smaller, then right if smaller than that
    assign pick_left  = left_ok && ($signed(mov_reg.value) > $signed(rd_a.value));
    assign best_val   = pick_left ? rd_a.value : mov_reg.value;
    assign pick_right = right_ok && (best_val > $signed(rd_b.value));

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_FIN) && rsp_ready;

    assign rsp.entry     = out_reg;
    assign rsp.status    = status_reg;
    assign rsp.occupancy = mhpq_pkg::OCC_W'(count_reg);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        hole_next   = hole_reg;
        mov_next    = mov_reg;
        out_next    = out_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = hole_reg;
        ram_wdata   = mov_reg;
        ram_ra      = '0;
        ram_rb      = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    out_next    = '0;
                    status_next = mhpq_pkg::STATUS_DONE;
                    if (req.action == mhpq_pkg::ACT_INSERT) begin
                        if (count_reg == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) begin
                            status_next = mhpq_pkg::STATUS_FULL;
                            state_next  = S_FIN;
                        end else begin
                            mov_next   = req.entry;
                            hole_next  = count_reg[mhpq_pkg::IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                            state_next = S_UP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = mhpq_pkg::STATUS_EMPTY;
                            state_next  = S_FIN;
                        end else begin
                            // fetch root and last entry together
                            ram_ra     = '0;
                            ram_rb     = count_dec[mhpq_pkg::IDX_W-1:0];
                            count_next = count_dec;
                            state_next = S_DN_LOAD;
                        end
                    end
                end
            end
            S_UP: begin
                if (hole_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = S_FIN;
                end else begin
                    ram_ra     = (hole_reg - 1'b1) >> 1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if ($signed(rd_a.value) > $signed(mov_reg.value)) begin
                    // move parent down into the hole
                    ram_wdata  = rd_a;
                    hole_next  = (hole_reg - 1'b1) >> 1;
                    state_next = S_UP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_DN_LOAD: begin
                out_next  = rd_a;
                mov_next  = rd_b;
                hole_next = '0;
                if (count_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_DN;
                end
            end
            S_DN: begin
                if (!left_ok) begin
                    ram_we     = 1'b1;
                    state_next = S_FIN;
                end else begin
                    ram_ra     = left_w[mhpq_pkg::IDX_W-1:0];
                    ram_rb     = right_w[mhpq_pkg::IDX_W-1:0];
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (pick_right) begin
                    ram_wdata  = rd_b;
                    hole_next  = right_w[mhpq_pkg::IDX_W-1:0];
                    state_next = S_DN;
                end else if (pick_left) begin
                    ram_wdata  = rd_a;
                    hole_next  = left_w[mhpq_pkg::IDX_W-1:0];
                    state_next = S_DN;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        hole_reg   <= hole_next;
        mov_reg    <= mov_next;
        out_reg    <= out_next;
        status_reg <= status_next;
    end

endmodule

@@ sv/min_heap_priority_queue_unit.sv @@
// Bounded binary min-heap priority queue, the ordering core of a k-way merge.
// Each item either inserts an entry (signed key, source stream, position) or
// extracts the entry with the smallest key; every item yields exactly one
// result carrying the extracted entry (zero for inserts), a status code (done,
// extract on empty, insert on full) and the occupancy after the operation.
// Equal keys never displace one another; only the key takes part in ordering.
// The heap lives in a dual-read-port RAM with a registered read. One item is
// processed at a time. A refused item (extract on empty, insert on full) goes
// straight to the result. An insert reads the parent and compares keys at
// each level it rises; an extract fetches the root and the last entry
// together, then reads both children and compares keys at each level it
// sinks. The engine then returns to idle before it takes the next item, so
// an item's time is set by the RAM read followed by a key compare at every
// heap level. A finished result sits in an output register, so the next item
// is taken while it waits; only when that register is still full and m_ready
// is low does the engine hold its result and stall.
module min_heap_priority_queue_unit (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic signed [31:0] s_entry_value,
    input  logic [3:0]         s_entry_source,
    input  logic [15:0]        s_entry_position,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_value,
    output logic [3:0]         m_out_source,
    output logic [15:0]        m_out_position,
    output logic [1:0]         m_status,
    output logic [4:0]         m_occupancy
);

    mhpq_pkg::op_req_t req;
    mhpq_pkg::op_rsp_t rsp;
    mhpq_pkg::op_rsp_t rsp_reg;
    logic              eng_idle;
    logic              eng_done;
    logic              rsp_ready;
    logic              m_valid_reg;

    // pack the item for the heap engine
    assign req.action         = s_action;
    assign req.entry.value    = s_entry_value;
    assign req.entry.source   = s_entry_source;
    assign req.entry.position = s_entry_position;

    // take a new item whenever the engine is idle
    assign s_ready = eng_idle;

    // the engine may hand over a result when the output slot is empty or frees this cycle
    assign rsp_ready = !m_valid_reg || m_ready;

    mhpq_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && s_ready),
        .req       (req),
        .idle      (eng_idle),
        .rsp_ready (rsp_ready),
        .done      (eng_done),
        .rsp       (rsp)
    );

    // output register: load on engine completion, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (eng_done) begin
            rsp_reg <= rsp;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_value    = rsp_reg.entry.value;
    assign m_out_source   = rsp_reg.entry.source;
    assign m_out_position = rsp_reg.entry.position;
    assign m_status       = rsp_reg.status;
    assign m_occupancy    = rsp_reg.occupancy;

endmodule
